// File: rtl/gppf_pkg.sv
// Shared constants and controller/datapath interface types for the Goldbach pair finder.
package gppf_pkg;

    localparam int NUMBER_WIDTH_DEF = 16;
    localparam int FIRST_WIDTH      = 15;
    localparam int SECOND_WIDTH     = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_n;      // capture the input number, set candidate p to two
        logic start_p;     // begin a primality test of p
        logic start_q;     // begin a primality test of number minus p
        logic div_start;   // launch one remainder computation
        logic step_d;      // advance the trial divisor and its square
        logic next_p;      // advance the candidate p
        logic load_out;    // capture the result item
        logic found;       // found flag for the captured result item
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_bad;       // number is odd or not greater than two
        logic sq_gt_v;     // trial divisor squared exceeds the tested value
        logic div_done;    // remainder is ready
        logic rem_zero;    // remainder is zero
        logic p_over;      // candidate p exceeds half the number
    } t_dp_status;

endpackage

// File: rtl/gppf_div.sv
// Sequential restoring remainder unit, one quotient bit per cycle.
module gppf_div
    import gppf_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_dividend,
    input  logic [NUMBER_WIDTH-1:0] i_divisor,
    output logic                    o_done,
    output logic [NUMBER_WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(NUMBER_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(NUMBER_WIDTH - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic [NUMBER_WIDTH-1:0] r_rem;
    logic [NUMBER_WIDTH-1:0] r_sh;
    logic [NUMBER_WIDTH:0]   trial;
    logic [NUMBER_WIDTH:0]   diff;

    assign trial = {r_rem, r_sh[NUMBER_WIDTH-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_sh  <= i_dividend;
        end else if (r_busy) begin
            r_sh <= {r_sh[NUMBER_WIDTH-2:0], 1'b0};
            if (!diff[NUMBER_WIDTH]) begin
                r_rem <= diff[NUMBER_WIDTH-1:0];
            end else begin
                r_rem <= trial[NUMBER_WIDTH-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("remainder done held longer than one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && !r_done) else $error("division did not start");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && (i_divisor != '0) |-> r_rem < i_divisor)
        else $error("remainder not below divisor");

endmodule

// File: rtl/gppf_dp.sv
// Datapath: number, candidate, tested value, trial divisor and its square, result registers.
module gppf_dp
    import gppf_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    output logic                    o_found,
    output logic [FIRST_WIDTH-1:0]  o_first_prime,
    output logic [SECOND_WIDTH-1:0] o_second_prime
);

    // The square of the divisor never passes twice the largest tested value.
    localparam int SW = NUMBER_WIDTH + 2;

    logic [NUMBER_WIDTH-1:0] r_n;
    logic [NUMBER_WIDTH-1:0] r_p;
    logic [NUMBER_WIDTH-1:0] r_v;
    logic [NUMBER_WIDTH-1:0] r_d;
    logic [SW-1:0]           r_sq;
    logic                    r_found;
    logic [FIRST_WIDTH-1:0]  r_first;
    logic [SECOND_WIDTH-1:0] r_second;

    logic [NUMBER_WIDTH-1:0] q;
    logic [NUMBER_WIDTH-1:0] rem;
    logic                    div_done;
    logic [NUMBER_WIDTH+FIRST_WIDTH-1:0]  p_ext;
    logic [NUMBER_WIDTH+SECOND_WIDTH-1:0] q_ext;

    assign q     = r_n - r_p;
    assign p_ext = {{FIRST_WIDTH{1'b0}}, r_p};
    assign q_ext = {{SECOND_WIDTH{1'b0}}, q};

    gppf_div #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_v),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_n) begin
            r_n <= i_number;
            r_p <= NUMBER_WIDTH'(2);
        end
        if (i_cmd.next_p) begin
            r_p <= r_p + 1'b1;
        end
        if (i_cmd.start_p || i_cmd.start_q) begin
            r_v  <= i_cmd.start_p ? r_p : q;
            r_d  <= NUMBER_WIDTH'(2);
            r_sq <= SW'(4);
        end else if (i_cmd.step_d) begin
            // (d + 1)^2 = d^2 + 2d + 1
            r_d  <= r_d + 1'b1;
            r_sq <= r_sq + {1'b0, r_d, 1'b0} + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_found  <= i_cmd.found;
            r_first  <= i_cmd.found ? p_ext[FIRST_WIDTH-1:0] : '0;
            r_second <= i_cmd.found ? q_ext[SECOND_WIDTH-1:0] : '0;
        end
    end

    assign o_status.n_bad    = r_n[0] || (r_n <= NUMBER_WIDTH'(2));
    assign o_status.sq_gt_v  = r_sq > {2'b00, r_v};
    assign o_status.div_done = div_done;
    assign o_status.rem_zero = (rem == '0);
    assign o_status.p_over   = r_p > (r_n >> 1);

    assign o_found        = r_found;
    assign o_first_prime  = r_first;
    assign o_second_prime = r_second;

endmodule

// File: rtl/gppf_ctrl.sv
// Controller: sequences the candidate search, the trial divisions and the result handshake.
module gppf_ctrl
    import gppf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK_N,
        S_PRIME_CHK,
        S_DIV_WAIT,
        S_NEXT_P,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_testing_q, n_testing_q;
    logic   r_found, n_found;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_testing_q = r_testing_q;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_n = 1'b1;
                    n_state      = S_CHECK_N;
                end
            end
            S_CHECK_N: begin
                if (i_status.n_bad) begin
                    n_found = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start_p = 1'b1;
                    n_testing_q   = 1'b0;
                    n_state       = S_PRIME_CHK;
                end
            end
            S_PRIME_CHK: begin
                if (i_status.sq_gt_v) begin
                    // No divisor up to the square root: the tested value is prime.
                    if (r_testing_q) begin
                        n_found = 1'b1;
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.start_q = 1'b1;
                        n_testing_q   = 1'b1;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    if (i_status.rem_zero) begin
                        o_cmd.next_p = 1'b1;
                        n_state      = S_NEXT_P;
                    end else begin
                        o_cmd.step_d = 1'b1;
                        n_state      = S_PRIME_CHK;
                    end
                end
            end
            S_NEXT_P: begin
                if (i_status.p_over) begin
                    n_found = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start_p = 1'b1;
                    n_testing_q   = 1'b0;
                    n_state       = S_PRIME_CHK;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.found = r_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_testing_q <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_testing_q <= n_testing_q;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && out_free |=> o_valid && (r_state == S_IDLE))
        else $error("finished result not presented");
    a_found_needs_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRIME_CHK) && (n_state == S_FINISH) |-> r_testing_q)
        else $error("pair reported before testing number minus p");
    a_wait_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_WAIT) |-> !o_cmd.div_start)
        else $error("division restarted while in flight");

endmodule

// File: rtl/goldbach_prime_pair_finder.sv
// Run time is data dependent: trial divisions of p and of number-p on the sequential remainder unit.
// Odd or small input goes straight to the result. One item is in work at a time; the next item
// is taken once the result sits in the output register, so the trial divisions and any output
// stall set the rate.
// Reset (synchronous, active low) returns the controller to idle and drops the output valid.
module goldbach_prime_pair_finder
    import gppf_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_found,
    output logic [FIRST_WIDTH-1:0]  o_first_prime,
    output logic [SECOND_WIDTH-1:0] o_second_prime
);

    t_dp_cmd    cmd;
    t_dp_status status;

    gppf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    gppf_dp #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_number       (i_number),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_found        (o_found),
        .o_first_prime  (o_first_prime),
        .o_second_prime (o_second_prime)
    );

endmodule
